[design/fmcp_pkg.sv]
// ----------------------------------------------------------------------------
// fmcp_pkg
// Shared types and constants of the framed ASCII motion command parser.
// ----------------------------------------------------------------------------
package fmcp_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_STATION_ADDR = 3'd0;
   localparam logic [2:0] REG_OPEN_CHAR    = 3'd1;
   localparam logic [2:0] REG_CLOSE_CHAR   = 3'd2;
   localparam logic [2:0] REG_POS_LIMIT    = 3'd3;
   localparam logic [2:0] REG_SPEED_MIN    = 3'd4;
   localparam logic [2:0] REG_STEP_SCALE   = 3'd5;

   localparam int CSR_DATA_W = 20;

   // register reset values
   localparam logic [7:0]  RST_STATION_ADDR = 8'd120;   // 'x'
   localparam logic [7:0]  RST_OPEN_CHAR    = 8'd60;    // '<'
   localparam logic [7:0]  RST_CLOSE_CHAR   = 8'd62;    // '>'
   localparam logic [19:0] RST_POS_LIMIT    = 20'd350000;
   localparam logic [9:0]  RST_SPEED_MIN    = 10'd14;
   localparam logic [10:0] RST_STEP_SCALE   = 11'd512;

   // characters
   localparam logic [7:0] CHAR_ZERO = 8'd48;
   localparam logic [7:0] CHAR_NINE = 8'd57;
   localparam logic [7:0] CMD_MOVE  = 8'd112;   // 'p'
   localparam logic [7:0] CMD_SWEEP = 8'd119;   // 'w'
   localparam logic [7:0] CMD_SPEED = 8'd115;   // 's'
   localparam logic [7:0] CMD_LASER = 8'd108;   // 'l'

   // frame lengths per command (address and letter included)
   localparam int LEN_MOVE  = 8;
   localparam int LEN_SWEEP = 14;
   localparam int LEN_SPEED = 5;
   localparam int LEN_LASER = 3;

   // digit field positions inside the frame
   localparam logic [3:0] POS_DIGIT0     = 4'd2;
   localparam logic [3:0] POS_MOVE_LAST  = 4'd7;
   localparam logic [3:0] POS_SWEEP_2ND  = 4'd8;
   localparam logic [3:0] POS_SWEEP_LAST = 4'd13;
   localparam logic [3:0] POS_SPEED_LAST = 4'd4;
   localparam logic [3:0] POS_LASER_LAST = 4'd2;

   // result kinds
   localparam logic [1:0] KIND_MOVE  = 2'd0;
   localparam logic [1:0] KIND_SWEEP = 2'd1;
   localparam logic [1:0] KIND_SPEED = 2'd2;
   localparam logic [1:0] KIND_LASER = 2'd3;

   // shared multiply-add unit
   localparam int MUL_W  = 30;
   localparam int PROD_W = 2 * MUL_W;
   // floor(y / 25) = (y * RECIP_25) >> 34, exact for y < 2**30
   localparam logic [MUL_W-1:0] RECIP_25  = 30'd687194768;
   localparam int               DIV_SHIFT = 34;
   localparam logic [23:0]      STEP_MAX  = 24'hFFFFFF;

   typedef struct packed {
      logic [7:0]  station_addr;
      logic [19:0] pos_limit;
      logic [9:0]  speed_min;
      logic [10:0] step_scale;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  command_kind;
      logic [23:0] first_steps;
      logic [23:0] second_steps;
      logic [9:0]  speed_value;
      logic        laser_on;
   } result_type;

endpackage

[design/fmcp_mac_unit.sv]
// ----------------------------------------------------------------------------
// fmcp_mac_unit
// Shared multiply-add unit with registered result: res = a * b + c.
// ----------------------------------------------------------------------------
module fmcp_mac_unit (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [fmcp_pkg::MUL_W-1:0]     op_a,
   input  logic [fmcp_pkg::MUL_W-1:0]     op_b,
   input  logic [3:0]                     op_c,
   output logic [fmcp_pkg::PROD_W-1:0]    result
);

   logic [fmcp_pkg::PROD_W-1:0] res_ff;
   logic [fmcp_pkg::PROD_W-1:0] res_in;

   assign res_in = fmcp_pkg::PROD_W'(op_a) * fmcp_pkg::PROD_W'(op_b)
                 + fmcp_pkg::PROD_W'(op_c);

   always_ff @(posedge clock) begin
      if (enable) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

[design/fmcp_frame_buf.sv]
// ----------------------------------------------------------------------------
// fmcp_frame_buf
// Frame delimiting and byte store, with one random read port.
// ----------------------------------------------------------------------------
module fmcp_frame_buf #(
   parameter int FRAME_BYTES = 14
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    rx_take,
   input  logic [7:0]                              rx_byte,
   input  logic [7:0]                              open_char,
   input  logic [7:0]                              close_char,
   input  logic [$clog2(FRAME_BYTES)-1:0]          rd_addr,
   output logic [7:0]                              rd_data,
   output logic [7:0]                              head_byte0,
   output logic [7:0]                              head_byte1,
   output logic [$clog2(FRAME_BYTES+1)-1:0]        frame_count,
   output logic                                    frame_overflow,
   output logic                                    frame_done
);

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam int CNT_W = $clog2(FRAME_BYTES + 1);

   logic             in_frame_ff, in_frame_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       store_ff [FRAME_BYTES];
   logic             is_open, is_close, room, wr_en;

   assign is_open  = (rx_byte == open_char);
   assign is_close = (rx_byte == close_char) && !is_open;
   assign room     = (32'(count_ff) < FRAME_BYTES);
   assign wr_en    = rx_take && !is_open && !is_close && in_frame_ff && room;

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      if (rx_take) begin
         if (is_open) begin
            in_frame_in = 1'b1;
            count_in    = '0;
            ovf_in      = 1'b0;
         end else if (is_close) begin
            in_frame_in = 1'b0;
         end else if (in_frame_ff) begin
            if (room) begin
               count_in = count_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[count_ff[IDX_W-1:0]] <= rx_byte;
      end
   end

   assign rd_data        = store_ff[rd_addr];
   assign head_byte0     = store_ff[0];
   assign head_byte1     = store_ff[1];
   assign frame_count    = count_ff;
   assign frame_overflow = ovf_ff;
   assign frame_done     = rx_take && is_close && in_frame_ff;

endmodule

[design/fmcp_decode_seq.sv]
// ----------------------------------------------------------------------------
// fmcp_decode_seq
// Sequencer that checks a closed frame, accumulates digits and scales
// positions to steps through the shared multiply-add unit.
// ----------------------------------------------------------------------------
module fmcp_decode_seq #(
   parameter int FRAME_BYTES = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  fmcp_pkg::cfg_type                    cfg,
   input  logic [7:0]                           head_byte0,
   input  logic [7:0]                           head_byte1,
   input  logic [$clog2(FRAME_BYTES+1)-1:0]     frame_count,
   input  logic                                 frame_overflow,
   input  logic [7:0]                           rd_data,
   output logic [$clog2(FRAME_BYTES)-1:0]       rd_addr,
   input  logic                                 out_free,
   output logic                                 busy,
   output logic                                 res_load,
   output fmcp_pkg::result_type                 res_data
);

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam int POS_W = (IDX_W > 4) ? IDX_W : 4;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_DIGIT = 3'd2;
   localparam logic [2:0] S_FIELD = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_SAT   = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [POS_W-1:0]     last_ff, last_in;
   logic                 second_ff, second_in;
   fmcp_pkg::result_type res_ff, res_in;

   logic                            mac_en;
   logic [fmcp_pkg::MUL_W-1:0]      mac_a, mac_b;
   logic [3:0]                      mac_c;
   logic [fmcp_pkg::PROD_W-1:0]     mac_res;
   logic [19:0]                     acc;
   logic [25:0]                     quot;
   logic [23:0]                     steps;
   logic                            is_digit;
   logic [31:0]                     cnt32;

   fmcp_mac_unit u_mac (
      .clock  (clock),
      .enable (mac_en),
      .op_a   (mac_a),
      .op_b   (mac_b),
      .op_c   (mac_c),
      .result (mac_res)
   );

   assign acc      = mac_res[19:0];
   assign quot     = mac_res[fmcp_pkg::DIV_SHIFT +: 26];
   assign steps    = (quot[25:24] != 2'b00) ? fmcp_pkg::STEP_MAX : quot[23:0];
   assign is_digit = (rd_data >= fmcp_pkg::CHAR_ZERO) && (rd_data <= fmcp_pkg::CHAR_NINE);
   assign cnt32    = 32'(frame_count);
   assign rd_addr  = pos_ff[IDX_W-1:0];

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      last_in   = last_ff;
      second_in = second_ff;
      res_in    = res_ff;
      mac_en    = 1'b0;
      mac_a     = '0;
      mac_b     = '0;
      mac_c     = '0;
      res_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // clear the accumulator for the first digit field
            mac_en    = 1'b1;
            pos_in    = POS_W'(fmcp_pkg::POS_DIGIT0);
            second_in = 1'b0;
            res_in    = '0;
            state_in  = S_DIGIT;
            if (frame_overflow || cnt32 < 32'd2 || head_byte0 != cfg.station_addr) begin
               state_in = S_IDLE;
            end else if (head_byte1 == fmcp_pkg::CMD_MOVE && cnt32 == fmcp_pkg::LEN_MOVE) begin
               res_in.command_kind = fmcp_pkg::KIND_MOVE;
               last_in = POS_W'(fmcp_pkg::POS_MOVE_LAST);
            end else if (head_byte1 == fmcp_pkg::CMD_SWEEP
                         && cnt32 == fmcp_pkg::LEN_SWEEP) begin
               res_in.command_kind = fmcp_pkg::KIND_SWEEP;
               last_in = POS_W'(fmcp_pkg::POS_MOVE_LAST);
            end else if (head_byte1 == fmcp_pkg::CMD_SPEED
                         && cnt32 == fmcp_pkg::LEN_SPEED) begin
               res_in.command_kind = fmcp_pkg::KIND_SPEED;
               last_in = POS_W'(fmcp_pkg::POS_SPEED_LAST);
            end else if (head_byte1 == fmcp_pkg::CMD_LASER
                         && cnt32 == fmcp_pkg::LEN_LASER) begin
               res_in.command_kind = fmcp_pkg::KIND_LASER;
               last_in = POS_W'(fmcp_pkg::POS_LASER_LAST);
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIGIT: begin
            // acc = acc * 10 + digit
            mac_en = 1'b1;
            mac_a  = fmcp_pkg::MUL_W'(acc);
            mac_b  = fmcp_pkg::MUL_W'(10);
            mac_c  = 4'(rd_data - fmcp_pkg::CHAR_ZERO);
            if (!is_digit) begin
               mac_en   = 1'b0;
               state_in = S_IDLE;
            end else if (pos_ff == last_ff) begin
               state_in = S_FIELD;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         S_FIELD: begin
            case (res_ff.command_kind)
               fmcp_pkg::KIND_SPEED: begin
                  res_in.speed_value = acc[9:0];
                  state_in = (acc < 20'(cfg.speed_min)) ? S_IDLE : S_EMIT;
               end
               fmcp_pkg::KIND_LASER: begin
                  res_in.laser_on = acc[0];
                  state_in = (acc > 20'd1) ? S_IDLE : S_EMIT;
               end
               default: begin
                  state_in = (acc > cfg.pos_limit) ? S_IDLE : S_MUL;
               end
            endcase
         end
         S_MUL: begin
            mac_en   = 1'b1;
            mac_a    = fmcp_pkg::MUL_W'(acc);
            mac_b    = fmcp_pkg::MUL_W'(cfg.step_scale);
            state_in = S_DIV;
         end
         S_DIV: begin
            // /100 as /4 then reciprocal of 25
            mac_en   = 1'b1;
            mac_a    = fmcp_pkg::MUL_W'(mac_res[30:2]);
            mac_b    = fmcp_pkg::RECIP_25;
            state_in = S_SAT;
         end
         S_SAT: begin
            if (second_ff) begin
               res_in.second_steps = steps;
               state_in = S_EMIT;
            end else begin
               res_in.first_steps = steps;
               if (res_ff.command_kind == fmcp_pkg::KIND_SWEEP) begin
                  // clear accumulator, go parse the stop position
                  mac_en    = 1'b1;
                  second_in = 1'b1;
                  pos_in    = POS_W'(fmcp_pkg::POS_SWEEP_2ND);
                  last_in   = POS_W'(fmcp_pkg::POS_SWEEP_LAST);
                  state_in  = S_DIGIT;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      last_ff   <= last_in;
      second_ff <= second_in;
      res_ff    <= res_in;
   end

   assign busy     = (state_ff != S_IDLE);
   assign res_data = res_ff;

endmodule

[design/framed_ascii_motion_command_parser.sv]
// ----------------------------------------------------------------------------
// framed_ascii_motion_command_parser
// Parses framed ASCII motion commands from a byte stream into decoded results.
// ----------------------------------------------------------------------------
// Bytes arrive one per transfer on the req_ channel. The open character
// starts a frame (and restarts one already open), the close character ends
// it; bytes between them are stored, up to FRAME_BYTES of them, and any byte
// beyond that marks the frame bad. Bytes outside a frame are dropped. After
// an ordinary byte the block is ready again right away. A closing byte
// starts the decoder, and req_stall stays high until it is done: a check
// step, the digits in turn, a range check per number, a multiply, divide and
// saturate step per position to scale it to steps, and a last step that hands
// the result to the output register and waits for it to empty. The decoder
// works step by step because the single shared multiply-add unit does digit
// accumulation, scaling and the divide by 100 in turn.
// A valid frame gives one transfer on the rsp_ channel; a bad frame gives
// none. Steps are floor(position * steps_per_um_x100 / 100), saturated at
// 24 bits. Configuration must be written by the user through csr_ only while
// the block is idle; the block itself has no check for this.
// ----------------------------------------------------------------------------
module framed_ascii_motion_command_parser #(
   parameter int FRAME_BYTES = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   // byte input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_rx_byte,
   // decoded results
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_command_kind,
   output logic [23:0]                       rsp_first_steps,
   output logic [23:0]                       rsp_second_steps,
   output logic [9:0]                        rsp_speed_value,
   output logic                              rsp_laser_on,
   // configuration writes
   input  logic                              csr_wr_en,
   input  logic [2:0]                        csr_index,
   input  logic [fmcp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam int CNT_W = $clog2(FRAME_BYTES + 1);

   // configuration registers
   logic [7:0]  open_char_ff;
   logic [7:0]  close_char_ff;
   fmcp_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.station_addr <= fmcp_pkg::RST_STATION_ADDR;
         open_char_ff        <= fmcp_pkg::RST_OPEN_CHAR;
         close_char_ff       <= fmcp_pkg::RST_CLOSE_CHAR;
         cfg_ff.pos_limit    <= fmcp_pkg::RST_POS_LIMIT;
         cfg_ff.speed_min    <= fmcp_pkg::RST_SPEED_MIN;
         cfg_ff.step_scale   <= fmcp_pkg::RST_STEP_SCALE;
      end else if (csr_wr_en) begin
         case (csr_index)
            fmcp_pkg::REG_STATION_ADDR: cfg_ff.station_addr <= csr_wdata[7:0];
            fmcp_pkg::REG_OPEN_CHAR:    open_char_ff        <= csr_wdata[7:0];
            fmcp_pkg::REG_CLOSE_CHAR:   close_char_ff       <= csr_wdata[7:0];
            fmcp_pkg::REG_POS_LIMIT:    cfg_ff.pos_limit    <= csr_wdata[19:0];
            fmcp_pkg::REG_SPEED_MIN:    cfg_ff.speed_min    <= csr_wdata[9:0];
            fmcp_pkg::REG_STEP_SCALE:   cfg_ff.step_scale   <= csr_wdata[10:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // input side: stalled only while the decoder runs
   logic busy;
   logic rx_take;

   assign req_stall = busy;
   assign rx_take   = req_valid && !busy;

   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data, head_byte0, head_byte1;
   logic [CNT_W-1:0] frame_count;
   logic             frame_overflow, frame_done;

   fmcp_frame_buf #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_frame_buf (
      .clock          (clock),
      .reset          (reset),
      .rx_take        (rx_take),
      .rx_byte        (req_rx_byte),
      .open_char      (open_char_ff),
      .close_char     (close_char_ff),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .head_byte0     (head_byte0),
      .head_byte1     (head_byte1),
      .frame_count    (frame_count),
      .frame_overflow (frame_overflow),
      .frame_done     (frame_done)
   );

   // output register; free when empty or being taken this cycle
   logic                 rsp_valid_ff, rsp_valid_in;
   fmcp_pkg::result_type rsp_ff;
   fmcp_pkg::result_type res_data;
   logic                 out_free, res_load;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   fmcp_decode_seq #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_decode_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (frame_done),
      .cfg            (cfg_ff),
      .head_byte0     (head_byte0),
      .head_byte1     (head_byte1),
      .frame_count    (frame_count),
      .frame_overflow (frame_overflow),
      .rd_data        (rd_data),
      .rd_addr        (rd_addr),
      .out_free       (out_free),
      .busy           (busy),
      .res_load       (res_load),
      .res_data       (res_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;   // transfer done
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res_data;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_kind = rsp_ff.command_kind;
   assign rsp_first_steps  = rsp_ff.first_steps;
   assign rsp_second_steps = rsp_ff.second_steps;
   assign rsp_speed_value  = rsp_ff.speed_value;
   assign rsp_laser_on     = rsp_ff.laser_on;

endmodule
